// File: rtl/qte_pkg.sv
// Package for the quaternion to Euler angles block.
// Holds shared widths, the stage-1 hand-off record and the CORDIC arctangent table.
// No dependencies.
package qte_pkg;

    localparam int QW        = 16;
    localparam int PW        = 36;
    localparam int CW        = 40;
    localparam int AW        = 32;
    localparam int TAB_LEN   = 24;
    localparam int SQ_BITS   = 29;
    localparam int ANG_PITCH = 11520;
    localparam int ANG_FULL  = 23040;

    typedef struct packed {
        logic signed [PW-1:0] sine;
        logic signed [PW-1:0] roll_num;
        logic signed [PW-1:0] roll_den;
        logic signed [PW-1:0] yaw_num;
        logic signed [PW-1:0] yaw_den;
        logic                 clamped;
    } front_item_t;

    localparam int FRONT_W = 5 * PW + 1;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] acc;
        logic                 zero;
    } cordic_state_t;

    function automatic logic signed [AW-1:0] atan_entry(input logic [4:0] i);
        logic signed [AW-1:0] v;
        begin
            v = '0;
            case (i)
                5'd0:  v = 32'sd47185920;
                5'd1:  v = 32'sd27855475;
                5'd2:  v = 32'sd14718068;
                5'd3:  v = 32'sd7471121;
                5'd4:  v = 32'sd3750058;
                5'd5:  v = 32'sd1876857;
                5'd6:  v = 32'sd938658;
                5'd7:  v = 32'sd469357;
                5'd8:  v = 32'sd234682;
                5'd9:  v = 32'sd117342;
                5'd10: v = 32'sd58671;
                5'd11: v = 32'sd29335;
                5'd12: v = 32'sd14668;
                5'd13: v = 32'sd7334;
                5'd14: v = 32'sd3667;
                5'd15: v = 32'sd1833;
                5'd16: v = 32'sd917;
                5'd17: v = 32'sd458;
                5'd18: v = 32'sd229;
                5'd19: v = 32'sd115;
                5'd20: v = 32'sd57;
                5'd21: v = 32'sd29;
                5'd22: v = 32'sd14;
                5'd23: v = 32'sd7;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: rtl/qte_front.sv
// Front part: forms the sine and the atan2 operands from one quaternion in two stages.
// Depends on qte_pkg.
module qte_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [15:0]        w,
    input  logic signed [15:0]        x,
    input  logic signed [15:0]        y,
    input  logic signed [15:0]        z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output qte_pkg::front_item_t      out_item
);
    import qte_pkg::*;

    logic                 v1_reg;
    logic signed [31:0]   xz_reg, wy_reg, yz_reg, wx_reg, xy_reg, wz_reg, ww_reg,
                          zz_reg, xx_reg;
    logic                 v2_reg;
    front_item_t          item_reg;
    logic                 adv2, adv1;
    logic signed [PW-1:0] s_raw, one;
    front_item_t          item_next;

    assign adv2      = !v2_reg || out_ready;
    assign adv1      = !v1_reg || adv2;
    assign in_ready  = adv1;
    assign out_valid = v2_reg;
    assign out_item  = item_reg;
    assign one       = PW'(64'sd1 <<< 28);

    always_comb
    begin
        s_raw                = (PW'(xz_reg) + PW'(wy_reg)) <<< 1;
        item_next.clamped    = (s_raw > one) || (s_raw < -one);
        item_next.sine       = (s_raw > one) ? one : ((s_raw < -one) ? -one : s_raw);
        item_next.roll_num   = (PW'(yz_reg) - PW'(wx_reg)) <<< 1;
        item_next.roll_den   = ((PW'(ww_reg) + PW'(zz_reg)) <<< 1) - one;
        item_next.yaw_num    = (PW'(xy_reg) - PW'(wz_reg)) <<< 1;
        item_next.yaw_den    = ((PW'(ww_reg) + PW'(xx_reg)) <<< 1) - one;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            xz_reg <= x * z;
            wy_reg <= w * y;
            yz_reg <= y * z;
            wx_reg <= w * x;
            xy_reg <= x * y;
            wz_reg <= w * z;
            ww_reg <= w * w;
            zz_reg <= z * z;
            xx_reg <= x * x;
        end
        if (adv2 && v1_reg) item_reg <= item_next;
    end

endmodule

// File: rtl/qte_fifo.sv
// Short queue that decouples the front part from the back part.
// Depends on nothing beyond its parameters.
module qte_fifo #(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= in_data;
    end

endmodule

// File: rtl/qte_back.sv
// Back part: pipelined square root for the cosine, then three unrolled CORDIC pipelines.
// Depends on qte_pkg.
module qte_back #(
    parameter int STEPS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qte_pkg::front_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [14:0]   pitch,
    output logic signed [15:0]   roll,
    output logic signed [15:0]   yaw,
    output logic                 clamped
);
    import qte_pkg::*;

    localparam int SQ_ST = SQ_BITS + 1;
    localparam int NST   = SQ_ST + 1 + STEPS + 1;

    logic [NST-1:0] v_reg;
    logic           adv;

    logic [57:0] sq_rem_reg  [SQ_ST];
    logic [28:0] sq_root_reg [SQ_ST];
    front_item_t sq_item_reg [SQ_ST];

    cordic_state_t cs_reg [3][STEPS+1];
    logic          flag_reg [STEPS+1];

    logic signed [14:0] pitch_reg;
    logic signed [15:0] roll_reg, yaw_reg;
    logic               clamped_reg;

    logic [28:0] sine_mag;
    logic [57:0] sine_sq;

    assign adv       = !v_reg[NST-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[NST-1];
    assign pitch     = pitch_reg;
    assign roll      = roll_reg;
    assign yaw       = yaw_reg;
    assign clamped   = clamped_reg;

    // The sine is already clamped to +-2^28, so its magnitude fits in 29 bits.
    assign sine_mag  = in_item.sine[PW-1] ? 29'(-in_item.sine) : 29'(in_item.sine);
    assign sine_sq   = sine_mag * sine_mag;

    function automatic cordic_state_t pre_turn(input logic signed [PW-1:0] yv,
                                               input logic signed [PW-1:0] xv);
        cordic_state_t st;
        logic signed [CW-1:0] xe, ye;
        begin
            xe      = CW'(xv);
            ye      = CW'(yv);
            st.zero = (xv == 0) && (yv == 0);
            st.acc  = '0;
            st.x    = xe;
            st.y    = ye;
            if (xe < 0)
            begin
                if (ye >= 0)
                begin
                    st.x   = ye;
                    st.y   = -xe;
                    st.acc = AW'(64'sd90 <<< 20);
                end
                else
                begin
                    st.x   = -ye;
                    st.y   = xe;
                    st.acc = -AW'(64'sd90 <<< 20);
                end
            end
            return st;
        end
    endfunction

    function automatic cordic_state_t rot(input cordic_state_t st, input int i);
        cordic_state_t o;
        logic signed [CW-1:0] dx, dy;
        begin
            dx = st.y >>> i;
            dy = st.x >>> i;
            o  = st;
            if (st.y > 0)
            begin
                o.x   = st.x + dx;
                o.y   = st.y - dy;
                o.acc = st.acc + atan_entry(5'(i));
            end
            else
            begin
                o.x   = st.x - dx;
                o.y   = st.y + dy;
                o.acc = st.acc - atan_entry(5'(i));
            end
            return o;
        end
    endfunction

    function automatic logic signed [19:0] to_units(input cordic_state_t st,
                                                   input int bound);
        logic signed [AW:0]  t;
        logic signed [19:0]  u, b;
        begin
            t = (AW+1)'(st.acc) + (AW+1)'(33'sd4096);
            u = 20'(t >>> 13);
            b = 20'(bound);
            if (st.zero) u = '0;
            else if (u > b) u = b;
            else if (u < -b) u = -b;
            return u;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg <= '0;
        else if (adv) v_reg <= {v_reg[NST-2:0], in_valid};
    end

    // One result bit of the square root per stage over 2^56 - s^2.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_item_reg[0] <= in_item;
            sq_rem_reg[0]  <= (58'd1 << 56) - sine_sq;
            sq_root_reg[0] <= '0;
            for (int k = 1; k < SQ_ST; k++)
            begin
                logic [57:0] trial;
                int          sh;
                sh    = 2 * (SQ_ST - 1 - k);
                trial = 58'({sq_root_reg[k-1], 2'b01}) << sh;
                sq_item_reg[k] <= sq_item_reg[k-1];
                if (sq_rem_reg[k-1] >= trial)
                begin
                    sq_rem_reg[k]  <= sq_rem_reg[k-1] - trial;
                    sq_root_reg[k] <= {sq_root_reg[k-1][27:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[k]  <= sq_rem_reg[k-1];
                    sq_root_reg[k] <= {sq_root_reg[k-1][27:0], 1'b0};
                end
            end
            cs_reg[0][0] <= pre_turn(sq_item_reg[SQ_ST-1].sine,
                                     PW'(sq_root_reg[SQ_ST-1]));
            cs_reg[1][0] <= pre_turn(sq_item_reg[SQ_ST-1].roll_num,
                                     sq_item_reg[SQ_ST-1].roll_den);
            cs_reg[2][0] <= pre_turn(sq_item_reg[SQ_ST-1].yaw_num,
                                     sq_item_reg[SQ_ST-1].yaw_den);
            flag_reg[0]  <= sq_item_reg[SQ_ST-1].clamped;
            for (int i = 0; i < STEPS; i++)
            begin
                for (int a = 0; a < 3; a++) cs_reg[a][i+1] <= rot(cs_reg[a][i], i);
                flag_reg[i+1] <= flag_reg[i];
            end
            pitch_reg   <= 15'(-to_units(cs_reg[0][STEPS], ANG_PITCH));
            roll_reg    <= 16'(to_units(cs_reg[1][STEPS], ANG_FULL));
            yaw_reg     <= 16'(to_units(cs_reg[2][STEPS], ANG_FULL));
            clamped_reg <= flag_reg[STEPS];
        end
    end

endmodule

// File: rtl/quaternion_to_euler_angles.sv
// Top level of the quaternion to Euler angles block.
// Instantiates qte_front, qte_fifo and qte_back; depends on qte_pkg.
//
// Channel  Dir  Beat contents
// s_axis   in   quat_w, quat_x, quat_y, quat_z (Q2.14 each)
// m_axis   out  pitch_angle, roll_angle, yaw_angle, sine_clamped
//
// One quaternion is taken per cycle while no back-pressure from m_axis reaches the input.
// The back pipeline holds the 30-stage square root and the unrolled CORDIC stages.
// Reset clears the valid bits and the queue pointers and count; no state is kept between beats.
// A stall at the output holds the back pipeline; the two-entry queue lets the front keep going until it fills.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // pitch_angle, roll_angle, yaw_angle, sine_clamped
);
    import qte_pkg::*;

    logic               f_valid, f_ready, b_valid, b_ready;
    front_item_t        f_item, b_item;
    logic signed [14:0] pitch;
    logic signed [15:0] roll, yaw;
    logic               clamped;

    qte_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .w(s_axis_tdata[15:0]), .x(s_axis_tdata[31:16]),
        .y(s_axis_tdata[47:32]), .z(s_axis_tdata[63:48]),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    qte_fifo #(.WIDTH(FRONT_W)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_item),
        .out_valid(b_valid), .out_ready(b_ready), .out_data(b_item)
    );

    qte_back #(.STEPS(CORDIC_STEPS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(b_valid), .in_ready(b_ready), .in_item(b_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .pitch(pitch), .roll(roll), .yaw(yaw), .clamped(clamped)
    );

    assign m_axis_tdata = {clamped, yaw, roll, pitch};

`ifndef SYNTH
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(pitch) <= 15'sd11520 && $signed(pitch) >= -15'sd11520))
        else $error("pitch out of range");
    a_clamp_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && clamped) |-> (pitch == 15'sd11520 || pitch == -15'sd11520))
        else $error("clamped sine without saturated pitch");
    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (roll <= 16'sd23040 && roll >= -16'sd23040))
        else $error("roll out of range");
`endif

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the quaternion to Euler angles block.
// Drives quaternions on the input stream, predicts each result in fixed point and
// checks the output stream field by field; depends on qte_pkg and the RTL.
module testbench;
    import qte_pkg::*;

    typedef struct {
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] yaw;
        logic               clamped;
    } angles_t;

    localparam longint ONE_Q28  = 64'sd1 <<< 28;
    localparam longint QUARTER  = 64'sd90 <<< 20;
    localparam int     STEPS    = 16;
    localparam int     WD_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    angles_t angle_queue[$];
    int      error_count;
    int      idle_cycles = 0;
    bit      steady_flow;

    quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        begin
            r = 0;
            b = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        end
    endfunction

    function automatic longint vector_angle(input longint yv, input longint xv);
        longint x;
        longint y;
        longint acc;
        longint t;
        longint dx;
        longint dy;
        begin
            x = xv;
            y = yv;
            acc = 0;
            if (x == 0 && y == 0)
                return 0;
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -t;
                    acc = QUARTER;
                end
                else
                begin
                    x = -y;
                    y = t;
                    acc = -QUARTER;
                end
            end
            for (int i = 0; i < STEPS && i < TAB_LEN; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    acc = acc + longint'(atan_entry(i[4:0]));
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    acc = acc - longint'(atan_entry(i[4:0]));
                end
            end
            return acc;
        end
    endfunction

    function automatic longint scale_angle(input longint acc, input longint bound);
        longint u;
        begin
            u = (acc + 4096) >>> 13;
            if (u > bound)
                u = bound;
            if (u < -bound)
                u = -bound;
            return u;
        end
    endfunction

    function automatic angles_t euler_angles(input logic [63:0] q);
        longint  w;
        longint  x;
        longint  y;
        longint  z;
        longint  s;
        longint  c;
        angles_t a;
        begin
            w = longint'($signed(q[15:0]));
            x = longint'($signed(q[31:16]));
            y = longint'($signed(q[47:32]));
            z = longint'($signed(q[63:48]));
            a.clamped = 1'b0;
            s = 2 * (x * z + w * y);
            if (s > ONE_Q28)
            begin
                s = ONE_Q28;
                a.clamped = 1'b1;
            end
            if (s < -ONE_Q28)
            begin
                s = -ONE_Q28;
                a.clamped = 1'b1;
            end
            c = longint'(int_sqrt((64'd1 << 56) - longint'(s * s)));
            a.pitch = 15'(-scale_angle(vector_angle(s, c), ANG_PITCH));
            a.roll = 16'(scale_angle(vector_angle(2 * (y * z - w * x),
                                                  2 * w * w - ONE_Q28 + 2 * z * z), ANG_FULL));
            a.yaw = 16'(scale_angle(vector_angle(2 * (x * y - w * z),
                                                 2 * w * w - ONE_Q28 + 2 * x * x), ANG_FULL));
            return a;
        end
    endfunction

    function automatic int gap_length();
        int r;
        begin
            if (steady_flow)
                return 0;
            r = $urandom_range(0, 99);
            if (r < 65)
                return 0;
            if (r < 95)
                return $urandom_range(1, 3);
            return $urandom_range(10, 60);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_quaternion(input logic signed [15:0] w, input logic signed [15:0] x,
                                   input logic signed [15:0] y, input logic signed [15:0] z);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata = {z, y, x, w};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        angle_queue.push_back(euler_angles(s_axis_tdata));
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_unit_quaternion();
        real a[4];
        real n;
        begin
            do
            begin
                n = 0.0;
                for (int i = 0; i < 4; i++)
                begin
                    a[i] = real'(int'($urandom_range(0, 65534)) - 32767);
                    n = n + a[i] * a[i];
                end
            end
            while (n < 1.0);
            n = $sqrt(n);
            send_quaternion(16'($rtoi(a[0] / n * 16384.0)), 16'($rtoi(a[1] / n * 16384.0)),
                            16'($rtoi(a[2] / n * 16384.0)), 16'($rtoi(a[3] / n * 16384.0)));
        end
    endtask

    task automatic test_directed();
        send_quaternion(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_quaternion(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_quaternion(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        send_quaternion(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
        send_quaternion(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
        send_quaternion(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
        send_quaternion(16'sd11585, 16'sd0, -16'sd11585, 16'sd0);
        send_quaternion(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_quaternion(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_quaternion(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
        send_quaternion(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        send_quaternion(16'sd32767, 16'sd0, 16'sd0, 16'sd0);
        send_quaternion(-16'sd32768, 16'sd0, 16'sd0, 16'sd0);
        send_quaternion(16'sd0, -16'sd32768, 16'sd0, 16'sd0);
        send_quaternion(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        send_quaternion(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192);
        send_quaternion(16'sd1, 16'sd0, 16'sd0, 16'sd0);
        send_quaternion(-16'sd1, 16'sd1, -16'sd1, 16'sd1);
        send_quaternion(16'sd11585, 16'sd11585, 16'sd0, 16'sd0);
        send_quaternion(16'sd11585, 16'sd0, 16'sd0, -16'sd11585);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 300 == 0)
                steady_flow = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 99) < 60)
                send_unit_quaternion();
            else
                send_quaternion(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 30; i++)
            send_unit_quaternion();
        wait (angle_queue.size() == 0);
        @(negedge clk);
        for (int i = 0; i < 30; i++)
            send_unit_quaternion();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        error_count = 0;
        steady_flow = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_drain_pause();
        test_random(1400);
        wait (angle_queue.size() == 0);
        repeat (100) @(negedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                m_axis_tready = 1'b0;
            else if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                stall = gap_length();
            end
        end
    end

    always @(posedge clk)
    begin
        angles_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (angle_queue.size() == 0)
                report_mismatch("unexpected beat count", 1, 0);
            else
            begin
                want = angle_queue.pop_front();
                if (m_axis_tdata[14:0] !== want.pitch)
                    report_mismatch("pitch_angle", $signed(m_axis_tdata[14:0]), want.pitch);
                if (m_axis_tdata[30:15] !== want.roll)
                    report_mismatch("roll_angle", $signed(m_axis_tdata[30:15]), want.roll);
                if (m_axis_tdata[46:31] !== want.yaw)
                    report_mismatch("yaw_angle", $signed(m_axis_tdata[46:31]), want.yaw);
                if (m_axis_tdata[47] !== want.clamped)
                    report_mismatch("sine_clamped", m_axis_tdata[47], want.clamped);
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
